// ===== rtl/crc_checked_frame_receiver_core_defines.svh =====
// Assertion macros used by the frame receiver engine.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef CRC_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CRCFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crcfr_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the frame receiver.
// No dependencies.
`default_nettype none

package crcfr_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_ID   = 3'd4;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hFC;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hFB;
  localparam logic [7:0] TAIL_FIRST_RST  = 8'hFD;
  localparam logic [7:0] TAIL_SECOND_RST = 8'hFE;
  localparam logic [7:0] ACTION_ID_RST   = 8'h02;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CRC  = 2'd1;
  localparam logic [1:0] ST_BAD_TAIL = 2'd2;

  // One byte into the CRC, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // CRC after the first sync byte, recomputed whenever that register changes.
  localparam logic [15:0] SYNC_SEED_RST = crc_feed(CRC_INIT, SYNC_FIRST_RST);

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  tail_first;
    logic [7:0]  tail_second;
    logic [7:0]  action_id;
    logic [15:0] sync_seed;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/crcfr_cfg_regs.sv =====
// Configuration register file of the frame receiver.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [crcfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i,
  output crcfr_pkg::cfg_t                     cfg_o
);

  crcfr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= crcfr_pkg::SYNC_FIRST_RST;
      cfg_q.sync_second <= crcfr_pkg::SYNC_SECOND_RST;
      cfg_q.tail_first  <= crcfr_pkg::TAIL_FIRST_RST;
      cfg_q.tail_second <= crcfr_pkg::TAIL_SECOND_RST;
      cfg_q.action_id   <= crcfr_pkg::ACTION_ID_RST;
      cfg_q.sync_seed   <= crcfr_pkg::SYNC_SEED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        crcfr_pkg::CFG_SYNC_FIRST: begin
          cfg_q.sync_first <= cfg_data_i;
          cfg_q.sync_seed  <= crcfr_pkg::crc_feed(crcfr_pkg::CRC_INIT, cfg_data_i);
        end
        crcfr_pkg::CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data_i;
        crcfr_pkg::CFG_TAIL_FIRST:  cfg_q.tail_first  <= cfg_data_i;
        crcfr_pkg::CFG_TAIL_SECOND: cfg_q.tail_second <= cfg_data_i;
        crcfr_pkg::CFG_ACTION_ID:   cfg_q.action_id   <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/crcfr_engine.sv =====
// Deframing state machine, running CRC and result register of the frame receiver.
// Depends on crcfr_pkg and crc_checked_frame_receiver_core_defines.svh.
`default_nettype none
`include "crc_checked_frame_receiver_core_defines.svh"

module crcfr_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire crcfr_pkg::cfg_t cfg_i,
  input  wire logic            byte_valid_i,
  input  wire logic [7:0]      byte_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [1:0]           status_o,
  output logic [7:0]           frame_id_o,
  output logic [7:0]           data_len_o,
  output logic [7:0]           first_payload_o,
  output logic                 action_update_o
);

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_SYNC2  = 4'd1;
  localparam logic [3:0] PH_ID     = 4'd2;
  localparam logic [3:0] PH_LEN    = 4'd3;
  localparam logic [3:0] PH_DATA   = 4'd4;
  localparam logic [3:0] PH_CRC_HI = 4'd5;
  localparam logic [3:0] PH_CRC_LO = 4'd6;
  localparam logic [3:0] PH_TAIL1  = 4'd7;
  localparam logic [3:0] PH_TAIL2  = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held_id_q, held_id_d;
  logic [7:0]  held_len_q, held_len_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic        tail_ok_q, tail_ok_d;

  logic        res_valid;
  logic [1:0]  res_status;
  logic        fire;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [7:0]  frame_id_q;
  logic [7:0]  data_len_q;
  logic [7:0]  first_payload_q;
  logic        action_update_q;

  // Result slot frees up when empty or taken this cycle.
  assign ready_o = !out_valid_q || !out_stall_i;
  assign fire    = byte_valid_i && ready_o;

  always_comb begin
    phase_d      = phase_q;
    crc_d        = crc_q;
    held_id_d    = held_id_q;
    held_len_d   = held_len_q;
    bytes_left_d = bytes_left_q;
    first_d      = first_q;
    crc_hi_d     = crc_hi_q;
    tail_ok_d    = tail_ok_q;
    res_valid    = 1'b0;
    res_status   = crcfr_pkg::ST_OK;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == cfg_i.sync_first) phase_d = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (byte_i == cfg_i.sync_second) begin
          crc_d   = crcfr_pkg::crc_feed(cfg_i.sync_seed, byte_i);
          phase_d = PH_ID;
        end else if (byte_i != cfg_i.sync_first) begin
          phase_d = PH_HUNT;
        end
      end
      PH_ID: begin
        held_id_d = byte_i;
        crc_d     = crcfr_pkg::crc_feed(crc_q, byte_i);
        phase_d   = PH_LEN;
      end
      PH_LEN: begin
        held_len_d   = byte_i;
        bytes_left_d = byte_i;
        first_d      = 8'h00;
        crc_d        = crcfr_pkg::crc_feed(crc_q, byte_i);
        phase_d      = (byte_i == 8'h00) ? PH_CRC_HI : PH_DATA;
      end
      PH_DATA: begin
        if (bytes_left_q == held_len_q) first_d = byte_i;
        crc_d        = crcfr_pkg::crc_feed(crc_q, byte_i);
        bytes_left_d = bytes_left_q - 8'd1;
        if (bytes_left_q == 8'd1) phase_d = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_hi_d = byte_i;
        phase_d  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if ({crc_hi_q, byte_i} != crc_q) begin
          res_valid  = 1'b1;
          res_status = crcfr_pkg::ST_BAD_CRC;
          phase_d    = PH_HUNT;
        end else begin
          phase_d = PH_TAIL1;
        end
      end
      PH_TAIL1: begin
        tail_ok_d = (byte_i == cfg_i.tail_first);
        phase_d   = PH_TAIL2;
      end
      PH_TAIL2: begin
        res_valid  = 1'b1;
        res_status = (tail_ok_q && byte_i == cfg_i.tail_second) ?
                     crcfr_pkg::ST_OK : crcfr_pkg::ST_BAD_TAIL;
        phase_d    = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      crc_q        <= crcfr_pkg::CRC_INIT;
      held_id_q    <= 8'h00;
      held_len_q   <= 8'h00;
      bytes_left_q <= 8'h00;
      first_q      <= 8'h00;
      crc_hi_q     <= 8'h00;
      tail_ok_q    <= 1'b0;
    end else if (fire) begin
      phase_q      <= phase_d;
      crc_q        <= crc_d;
      held_id_q    <= held_id_d;
      held_len_q   <= held_len_d;
      bytes_left_q <= bytes_left_d;
      first_q      <= first_d;
      crc_hi_q     <= crc_hi_d;
      tail_ok_q    <= tail_ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      status_q        <= res_status;
      frame_id_q      <= held_id_q;
      data_len_q      <= held_len_q;
      first_payload_q <= first_q;
      action_update_q <= (res_status == crcfr_pkg::ST_OK) &&
                         (held_id_q == cfg_i.action_id) && (held_len_q != 8'h00);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign frame_id_o      = frame_id_q;
  assign data_len_o      = data_len_q;
  assign first_payload_o = first_payload_q;
  assign action_update_o = action_update_q;

  `CRCFR_ASSERT_NOW(a_result_phase, fire && res_valid,
                    phase_q == PH_CRC_LO || phase_q == PH_TAIL2, "result outside frame end")
  `CRCFR_ASSERT_NOW(a_data_count, phase_q == PH_DATA, bytes_left_q != 8'h00,
                    "payload phase with no bytes left")
  `CRCFR_ASSERT_NOW(a_action_ok, out_valid_q && action_update_q,
                    status_q == crcfr_pkg::ST_OK && data_len_q != 8'h00,
                    "action flag on rejected or empty frame")
  `CRCFR_ASSERT_NEXT(a_hunt_after_end, fire && res_valid,
                     phase_q == PH_HUNT && out_valid_q, "frame end did not return to hunt")

endmodule

`default_nettype wire

// ===== rtl/crc_checked_frame_receiver_core.sv =====
// Frame receiver with sync search, length field and CRC-16/CCITT-FALSE check.
//
// Input channel: in_valid_i / in_stall_o with rx_byte_i, one received byte per item.
// Output channel: out_valid_o / out_stall_i with status_o, frame_id_o, data_len_o,
// first_payload_o and action_update_o; one item per ended frame (CRC mismatch at the
// low CRC byte, otherwise after the second tail byte).
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; always
// ready, indexes 0..4 are sync_first, sync_second, tail_first, tail_second, action_id.
// Throughput: one byte per cycle unless out_stall_i holds a result. A byte goes
// through an input register, then the deframing logic (one 8-bit CRC update) into
// the result register, which then shows the result of the byte that ends the frame.
// Stall: a result held under out_stall_i holds the engine; an empty input register
// still takes one more byte, after which in_stall_o rises until the result is taken.
// Reset: asynchronous, active low; control and config registers return to defaults,
// the search restarts at the first sync byte and both item registers are emptied.
// Dependencies: crcfr_pkg, crcfr_cfg_regs, crcfr_engine.
`default_nettype none

module crc_checked_frame_receiver_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     rx_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [1:0]                          status_o,
  output logic [7:0]                          frame_id_o,
  output logic [7:0]                          data_len_o,
  output logic [7:0]                          first_payload_o,
  output logic                                action_update_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [crcfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i
);

  crcfr_pkg::cfg_t cfg;
  logic            byte_valid_q;
  logic [7:0]      byte_q;
  logic            eng_ready;

  assign cfg_ready_o = 1'b1;

  crcfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Hold the input register only while it is full and the engine cannot take it.
  assign in_stall_o = byte_valid_q && !eng_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  crcfr_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .byte_valid_i    (byte_valid_q),
    .byte_i          (byte_q),
    .ready_o         (eng_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .frame_id_o      (frame_id_o),
    .data_len_o      (data_len_o),
    .first_payload_o (first_payload_o),
    .action_update_o (action_update_o)
  );

endmodule

`default_nettype wire
